/* hw/rtl/event_ring_fifo_macros.svh */
// Assertion macros shared by the event ring queue checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef EVENT_RING_FIFO_MACROS_SVH
`define EVENT_RING_FIFO_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define ERF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held
`define ERF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define ERF_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/erf_pkg.sv */
// Shared types and constants for the event ring queue.
// No dependencies; imported by the top level, its checker and the bench.
package erf_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int EVENT_BITS_DEF = 64;

    localparam int OP_W     = 3;
    localparam int EVENT_W  = 64;
    localparam int COUNT_W  = 8;
    localparam int LEVEL_W  = 8;

    // request: tdata = event_in, count, offset; tuser = op
    localparam int S_TDATA_W = EVENT_W + COUNT_W + COUNT_W;
    localparam int S_TUSER_W = OP_W;
    // result: tdata = event_out, moved, level, room; tuser = ok
    localparam int M_TDATA_W = EVENT_W + 3 * LEVEL_W;
    localparam int M_TUSER_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_BATCH = 3'd2,
        OP_PEEK  = 3'd3,
        OP_RESET = 3'd4
    } t_op;

endpackage

/* hw/rtl/event_ring_fifo.sv */
// Event ring queue: power-of-two circular buffer, one slot kept empty.
// Request path: stage 1 register (slot read), then the output register.
// Throughput: one request per cycle while results are taken; the slot memory is read
// once per request and its registered read data is held until the result moves on.
// Reset (i_rst_n low, synchronous): pointers zero, queue empty, no result pending.
// Slot contents are not cleared; only written slots are ever returned.
module event_ring_fifo #(
    parameter int DEPTH      = erf_pkg::DEPTH_DEF,
    parameter int EVENT_BITS = erf_pkg::EVENT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: event_in[63:0], count[71:64], offset[79:72]
    input  logic [erf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: op[2:0]
    input  logic [erf_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: event_out[63:0], moved[71:64], level[79:72], room[87:80]
    output logic [erf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: ok[0]
    output logic [erf_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import erf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    // compare width for count/offset against the fill level
    localparam int CW    = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    // ---------------------------------------------------------------
    // Request field unpacking
    // ---------------------------------------------------------------
    t_op                   req_op;
    logic [EVENT_BITS-1:0] req_event;
    logic [COUNT_W-1:0]    req_count;
    logic [COUNT_W-1:0]    req_offset;

    assign req_op     = t_op'(s_axis_tuser[OP_W-1:0]);
    assign req_event  = EVENT_BITS'(s_axis_tdata[EVENT_W-1:0]);
    assign req_count  = s_axis_tdata[EVENT_W +: COUNT_W];
    assign req_offset = s_axis_tdata[EVENT_W+COUNT_W +: COUNT_W];

    // ---------------------------------------------------------------
    // Pointer state and slot memory
    // ---------------------------------------------------------------
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [EVENT_BITS-1:0] r_slots [DEPTH];
    logic [EVENT_BITS-1:0] r_rd_data;

    // Stage 1: request has read the slot memory, waiting for the output register
    logic                  r_s1_valid;
    logic                  r_s1_ok, n_s1_ok;
    logic                  r_s1_use_rd, n_s1_use_rd;
    logic [COUNT_W-1:0]    r_s1_moved, n_s1_moved;
    logic [LEVEL_W-1:0]    r_s1_level;
    logic [LEVEL_W-1:0]    r_s1_room;

    // Output register
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [EVENT_W-1:0]    r_out_event;
    logic [COUNT_W-1:0]    r_out_moved;
    logic [LEVEL_W-1:0]    r_out_level;
    logic [LEVEL_W-1:0]    r_out_room;

    logic                  req_fire;
    logic                  s1_go;
    logic                  wr_en;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [PTR_W-1:0]      cur_level;
    logic [PTR_W-1:0]      new_level;
    logic [PTR_W-1:0]      wr_next;

    // Stage 1 moves on when the output register is free or being drained;
    // a new request enters whenever stage 1 is empty or moving on.
    assign s1_go         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign req_fire      = s_axis_tvalid && s_axis_tready;

    assign cur_level = r_wr_ptr - r_rd_ptr;
    assign wr_next   = r_wr_ptr + PTR_W'(1);
    assign new_level = n_wr_ptr - n_rd_ptr;

    // ---------------------------------------------------------------
    // Operation decode: pointer update, slot write/read, result flags
    // ---------------------------------------------------------------
    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_s1_ok     = 1'b0;
        n_s1_use_rd = 1'b0;
        n_s1_moved  = '0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_rd_ptr;
        case (req_op)
            OP_PUSH: begin
                // full when advancing would land on the oldest entry
                if (wr_next != r_rd_ptr) begin
                    wr_en    = req_fire;
                    n_wr_ptr = wr_next;
                    n_s1_ok  = 1'b1;
                end
            end
            OP_POP: begin
                if (cur_level != '0) begin
                    rd_en       = req_fire;
                    n_rd_ptr    = r_rd_ptr + PTR_W'(1);
                    n_s1_ok     = 1'b1;
                    n_s1_use_rd = 1'b1;
                end
            end
            OP_BATCH: begin
                // clamp the discard to what is held
                if (CW'(req_count) < CW'(cur_level)) begin
                    n_s1_moved = req_count;
                end else begin
                    n_s1_moved = COUNT_W'(cur_level);
                end
                if (n_s1_moved != '0) begin
                    n_rd_ptr = PTR_W'(CW'(r_rd_ptr) + CW'(n_s1_moved));
                    n_s1_ok  = 1'b1;
                end
            end
            OP_PEEK: begin
                if (CW'(req_offset) < CW'(cur_level)) begin
                    rd_en       = req_fire;
                    rd_addr     = PTR_W'(CW'(r_rd_ptr) + CW'(req_offset));
                    n_s1_ok     = 1'b1;
                    n_s1_use_rd = 1'b1;
                end
            end
            OP_RESET: begin
                n_wr_ptr = '0;
                n_rd_ptr = '0;
                n_s1_ok  = 1'b1;
            end
            default: begin
                // unused codes leave the queue alone and report ok low
            end
        endcase
    end

    // Pointers advance only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else if (req_fire) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // Slot memory: one write port, one registered read port. A request reads
    // only slots written by earlier requests, so no bypass is needed; the read
    // data holds while stage 1 stalls since reads happen only on acceptance.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[r_wr_ptr] <= req_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_slots[rd_addr];
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload: level and room reflect the queue after this request
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_ok     <= n_s1_ok;
            r_s1_use_rd <= n_s1_use_rd;
            r_s1_moved  <= n_s1_moved;
            r_s1_level  <= LEVEL_W'(new_level);
            r_s1_room   <= LEVEL_W'(PTR_W'(DEPTH - 1) - new_level);
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_ok    <= r_s1_ok;
            // drop stale read data when the request returned no event
            r_out_event <= r_s1_use_rd ? EVENT_W'(r_rd_data) : '0;
            r_out_moved <= r_s1_moved;
            r_out_level <= r_s1_level;
            r_out_room  <= r_s1_room;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_room, r_out_level, r_out_moved, r_out_event};
    assign m_axis_tuser  = r_out_ok;

endmodule

/* hw/rtl/event_ring_fifo_chk.sv */
// Port-level checker for the event ring queue, bound to the top level.
// Depends on erf_pkg and event_ring_fifo_macros.svh.
`include "event_ring_fifo_macros.svh"

module event_ring_fifo_chk #(
    parameter int DEPTH = erf_pkg::DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [erf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [erf_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import erf_pkg::*;

    logic [LEVEL_W-1:0] chk_moved;
    logic [LEVEL_W-1:0] chk_level;
    logic [LEVEL_W-1:0] chk_room;
    logic [LEVEL_W-1:0] chk_sum;

    assign chk_moved = m_axis_tdata[EVENT_W +: LEVEL_W];
    assign chk_level = m_axis_tdata[EVENT_W+LEVEL_W +: LEVEL_W];
    assign chk_room  = m_axis_tdata[EVENT_W+2*LEVEL_W +: LEVEL_W];
    assign chk_sum   = chk_level + chk_room;

    `ERF_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `ERF_ASSERT_IMPL(a_level_room, m_axis_tvalid && (DEPTH <= 256), chk_sum == LEVEL_W'(DEPTH - 1), "level and room do not add up to capacity")
    `ERF_ASSERT_IMPL(a_moved_ok, m_axis_tvalid && (chk_moved != '0), m_axis_tuser[0], "discard reported without ok")
    `ERF_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, !m_axis_tvalid, "result pending after reset")

endmodule

bind event_ring_fifo event_ring_fifo_chk #(
    .DEPTH(DEPTH)
) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/erf_board_pkg.sv */
// Scoreboard for the event ring queue bench: a predictor of the queue and a store of
// the results it expects. Depends on erf_pkg for the operation codes and widths.
`timescale 1ns / 100ps

package erf_board_pkg;

    import erf_pkg::*;

    localparam int SLOTS       = erf_pkg::DEPTH_DEF;
    localparam int PTR_W       = $clog2(SLOTS);

    typedef struct packed {
        logic               ok;
        logic [EVENT_W-1:0] event_word;
        logic [LEVEL_W-1:0] moved;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] room;
    } t_erf_result;

    class t_event_queue_board;
        logic [EVENT_W-1:0] slot_mem [0:SLOTS-1];
        logic [PTR_W-1:0]   wr_ptr;
        logic [PTR_W-1:0]   rd_ptr;
        t_erf_result        expected_results [$];
        int unsigned        mismatch_count;
        int unsigned        request_count;
        int unsigned        result_count;
        int unsigned        full_refusals;
        int unsigned        peak_level;

        function new();
            wr_ptr         = '0;
            rd_ptr         = '0;
            mismatch_count = 0;
            request_count  = 0;
            result_count   = 0;
            full_refusals  = 0;
            peak_level     = 0;
        endfunction

        function logic [LEVEL_W-1:0] fill_level();
            return LEVEL_W'(wr_ptr - rd_ptr);
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Apply one accepted request to the shadow queue and store its result
        function void note_request(input logic [OP_W-1:0]    op,
                                   input logic [EVENT_W-1:0] ev,
                                   input logic [COUNT_W-1:0] cnt,
                                   input logic [COUNT_W-1:0] off);
            t_erf_result        r;
            logic [LEVEL_W-1:0] lvl;
            lvl = fill_level();
            r   = '0;
            case (op)
                OP_PUSH: begin
                    if (PTR_W'(wr_ptr + 1'b1) != rd_ptr) begin
                        slot_mem[wr_ptr] = ev;
                        wr_ptr           = PTR_W'(wr_ptr + 1'b1);
                        r.ok             = 1'b1;
                    end else begin
                        full_refusals++;
                    end
                end
                OP_POP: begin
                    if (lvl != 0) begin
                        r.event_word = slot_mem[rd_ptr];
                        rd_ptr       = PTR_W'(rd_ptr + 1'b1);
                        r.ok         = 1'b1;
                    end
                end
                OP_BATCH: begin
                    // clamp to what is held
                    r.moved = (cnt < lvl) ? cnt : lvl;
                    if (r.moved != 0) begin
                        rd_ptr = PTR_W'(rd_ptr + r.moved);
                        r.ok   = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (off < lvl) begin
                        r.event_word = slot_mem[PTR_W'(rd_ptr + off)];
                        r.ok         = 1'b1;
                    end
                end
                OP_RESET: begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                    r.ok   = 1'b1;
                end
                default: ;
            endcase
            r.level = fill_level();
            r.room  = LEVEL_W'(SLOTS - 1 - r.level);
            if (r.level > peak_level) peak_level = r.level;
            request_count++;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            mismatch_count++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Compare one result against the oldest outstanding expectation
        task check_result(input t_erf_result got);
            t_erf_result want;
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                          result_count));
                return;
            end
            want = expected_results.pop_front();
            if (got.ok !== want.ok)
                report_mismatch($sformatf("result %0d ok: got %b want %b",
                                          result_count, got.ok, want.ok));
            if (got.event_word !== want.event_word)
                report_mismatch($sformatf("result %0d event_out: got %h want %h",
                                          result_count, got.event_word, want.event_word));
            if (got.moved !== want.moved)
                report_mismatch($sformatf("result %0d moved: got %0d want %0d",
                                          result_count, got.moved, want.moved));
            if (got.level !== want.level)
                report_mismatch($sformatf("result %0d level: got %0d want %0d",
                                          result_count, got.level, want.level));
            if (got.room !== want.room)
                report_mismatch($sformatf("result %0d room: got %0d want %0d",
                                          result_count, got.room, want.room));
        endtask

        task finish_check();
            if (expected_results.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_results.size()));
        endtask
    endclass

endpackage

/* dv/tb_event_ring_fifo.sv */
// Top-level bench for event_ring_fifo: drives requests on the slave stream, collects
// results on the master stream and checks them. Depends on erf_pkg and erf_board_pkg.
`timescale 1ns / 100ps

module tb_event_ring_fifo;

    import erf_pkg::*;
    import erf_board_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int RAND_PER_PHASE = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 8;
    localparam int CYCLE_LIMIT    = 200000;

    // Bias of the random operation mix within one segment
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_ANY } t_mix;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // Idle percentages per side, set by the stimulus phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // Long receiver hold-off: armed by the stimulus, carried out by the sink
    bit          hold_armed    = 1'b0;
    bit          hold_taken    = 1'b0;
    int unsigned requests_sent = 0;
    int unsigned cycle_count   = 0;

    t_event_queue_board board;

    event_ring_fifo uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Guard against a hung handshake: end the run once the cycle budget is spent
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result sink: random back-pressure, plus one long hold-off when armed.
    // Only one nonblocking write to tready per edge.
    initial begin : result_sink
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Collect every accepted result and hand it to the scoreboard.
    // Values read here are the ones present before the edge.
    always @(posedge i_clk) begin : result_monitor
        t_erf_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok         = m_axis_tuser[0];
            got.event_word = m_axis_tdata[EVENT_W-1:0];
            got.moved      = m_axis_tdata[EVENT_W +: LEVEL_W];
            got.level      = m_axis_tdata[EVENT_W + LEVEL_W +: LEVEL_W];
            got.room       = m_axis_tdata[EVENT_W + 2*LEVEL_W +: LEVEL_W];
            board.check_result(got);
        end
    end

    // Offer one request, with random idle cycles in front of it, and hold it until
    // accepted. Returns at the accepting edge with tvalid still high, so a following
    // request can go out back to back without touching tvalid twice in one step.
    task automatic send_req(input logic [OP_W-1:0]    op,
                            input logic [EVENT_W-1:0] ev,
                            input logic [COUNT_W-1:0] cnt,
                            input logic [COUNT_W-1:0] off);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {off, cnt, ev};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(op, ev, cnt, off);
        requests_sent++;
    endtask

    // Drop tvalid and hold off until every outstanding result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Directed opening: empty-queue cases, event extremes, peek edges, batch clamp,
    // unused op codes and emptying a non-empty queue
    task automatic run_directed();
        send_req(OP_POP,   '0, '0, '0);              // pop when empty
        send_req(OP_PEEK,  '0, '0, '0);              // peek on empty queue
        send_req(OP_BATCH, '0, 8'hFF, '0);           // batch on empty queue
        send_req(OP_RESET, '0, '0, '0);
        send_req(OP_PUSH,  64'h0, 8'hFF, 8'hFF);
        send_req(OP_PUSH,  '1, '0, '0);
        send_req(OP_PUSH,  64'h8000_0000_0000_0001, 8'h55, 8'hAA);
        send_req(OP_PUSH,  64'h5555_AAAA_5555_AAAA, 8'hAA, 8'h55);
        send_req(OP_PEEK,  '0, '0, 8'd0);
        send_req(OP_PEEK,  '0, '0, 8'd3);            // last held entry
        send_req(OP_PEEK,  '0, '0, 8'd4);            // one beyond the level
        send_req(OP_PEEK,  '0, '0, 8'hFF);
        send_req(OP_BATCH, '0, 8'd0, '0);            // zero count discards nothing
        send_req(OP_POP,   '1, '0, '0);
        send_req(OP_BATCH, '0, 8'd1, '0);
        for (int k = 1; k <= 3; k++)                 // unused op codes
            send_req(3'(OP_RESET) + 3'(k), '1, 8'hFF, 8'hFF);
        send_req(OP_BATCH, '0, 8'hFF, '0);           // clamped to the level
        send_req(OP_PUSH,  64'hDEAD_BEEF_0123_4567, '0, '0);
        send_req(OP_PUSH,  64'hFEDC_BA98_7654_3210, '0, '0);
        send_req(OP_RESET, '1, 8'hFF, 8'hFF);        // empty a non-empty queue
        send_req(OP_POP,   '0, '0, '0);
        send_req(OP_PUSH,  64'h0F0F_0F0F_F0F0_F0F0, '0, '0);
        send_req(OP_PEEK,  '0, '0, 8'd0);
    endtask

    // One random request; unused fields always carry random data
    task automatic send_random(input t_mix mix);
        int unsigned        roll;
        int unsigned        cnt_top;
        logic [OP_W-1:0]    op;
        logic [EVENT_W-1:0] ev;
        logic [COUNT_W-1:0] cnt;
        logic [COUNT_W-1:0] off;
        logic [LEVEL_W-1:0] lvl;
        lvl  = board.fill_level();
        ev   = {$urandom, $urandom};
        cnt  = COUNT_W'($urandom);
        off  = COUNT_W'($urandom);
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                op = roll < 82 ? OP_PUSH : roll < 89 ? OP_POP : roll < 97 ? OP_PEEK : OP_BATCH;
            MIX_DRAIN:
                op = roll < 20 ? OP_PUSH : roll < 60 ? OP_POP : roll < 80 ? OP_BATCH : OP_PEEK;
            default: begin
                if (roll < 45)      op = OP_PUSH;
                else if (roll < 70) op = OP_POP;
                else if (roll < 78) op = OP_BATCH;
                else if (roll < 93) op = OP_PEEK;
                else if (roll < 96) op = OP_RESET;
                else                op = 3'(OP_RESET) + 3'($urandom_range(1, 3));
            end
        endcase
        // Keep most batch counts near the level and most peeks inside it or just past
        if (op == OP_BATCH) begin
            roll    = $urandom_range(0, 9);
            cnt_top = (lvl < SLOTS - 3) ? lvl + 2 : SLOTS - 1;
            if (roll < 5)      cnt = COUNT_W'($urandom_range(0, 4));
            else if (roll < 8) cnt = COUNT_W'($urandom_range(0, cnt_top));
        end else if (op == OP_PEEK) begin
            if ($urandom_range(0, 9) < 7) off = COUNT_W'($urandom_range(0, lvl));
        end
        send_req(op, ev, cnt, off);
    endtask

    // Push until full and beyond, peek at the far end, then wrap and drain a batch
    task automatic fill_to_full();
        int n;
        n = SLOTS - 1 - int'(board.fill_level()) + 3;
        repeat (n) send_req(OP_PUSH, {$urandom, $urandom}, COUNT_W'($urandom), COUNT_W'($urandom));
        send_req(OP_PEEK, '0, '0, COUNT_W'(SLOTS - 3));
        send_req(OP_PEEK, '0, '0, COUNT_W'(SLOTS - 2));
        send_req(OP_PEEK, '0, '0, COUNT_W'(SLOTS - 1));
        send_req(OP_POP,  '0, '0, '0);
        send_req(OP_PUSH, {$urandom, $urandom}, '0, '0);
        send_req(OP_BATCH, '0, COUNT_W'($urandom_range(100, 250)), '0);
    endtask

    initial begin : stimulus
        int unsigned phase_start;
        int unsigned seg_len;
        int unsigned roll;
        t_mix        mix;
        bit          burst_done;
        board = new();
        burst_done = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_rst_n       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Three phases: sender busy and receiver stalling, the reverse, then no idling
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // sender pause: let the block run dry before the second phase
            if (phase == 1) wait_drained();
            phase_start = requests_sent;
            while (requests_sent - phase_start < RAND_PER_PHASE) begin
                seg_len = $urandom_range(20, 60);
                roll    = $urandom_range(0, 99);
                mix     = roll < 40 ? MIX_FILL : roll < 65 ? MIX_DRAIN : MIX_ANY;
                // long receiver hold-off while the sender keeps pushing
                if (phase == 0 && !hold_armed && requests_sent - phase_start >= 60) begin
                    hold_armed = 1'b1;
                    mix        = MIX_FILL;
                end
                if (phase == 2 && !burst_done && requests_sent - phase_start >= 80) begin
                    burst_done = 1'b1;
                    fill_to_full();
                end else begin
                    repeat (seg_len) send_random(mix);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        board.finish_check();

        $display("Checked %0d results for %0d requests; peak level %0d, %0d pushes refused full.",
                 board.result_count, board.request_count, board.peak_level, board.full_refusals);
        $display("Phases ran with sender and receiver idling in turn, one long hold-off.");
        if (board.mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", board.mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
